FILE: hdl/pta_pkg.sv
// ----------------------------------------------------------------------------
// pta_pkg
// Shared widths, fixed-point constants, types and state codes for the
// peak-tracking AGC.
// ----------------------------------------------------------------------------
package pta_pkg;

    // sample and result formats
    localparam int SAMPLE_BITS  = 16;              // signed Q1.(SAMPLE_BITS-1)
    localparam int OUT_BITS     = 16;              // signed Q2.14
    localparam int OUT_FRAC     = 14;
    localparam int PEAK_BITS    = 32;              // signed Q1.31
    localparam int REL_BITS     = 32;              // unsigned Q0.32
    localparam int PROD_BITS    = PEAK_BITS + REL_BITS;
    localparam int SAMPLE_SHIFT = PEAK_BITS - SAMPLE_BITS;

    // divider: quotient carries one bit more than the output width
    localparam int QUO_BITS     = OUT_BITS + 1;
    localparam int CNT_BITS     = $clog2(QUO_BITS);
    localparam int REM_SHIFT    = PEAK_BITS + OUT_FRAC - SAMPLE_BITS - QUO_BITS;

    localparam logic [QUO_BITS-1:0] NEG_LIMIT = QUO_BITS'(1) << (OUT_BITS - 1);
    localparam logic [QUO_BITS-1:0] POS_LIMIT = NEG_LIMIT - QUO_BITS'(1);
    localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // register port
    localparam int   PADDR_BITS      = 3;
    localparam int   PDATA_BITS      = 32;
    localparam logic REG_RELEASE_IDX = 1'b0;
    localparam logic [REL_BITS-1:0] RELEASE_RESET = {REL_BITS{1'b1}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic        [SAMPLE_BITS-1:0] mag;
        logic                          neg;
        logic                          block_end;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_CHK,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

FILE: hdl/peak_tracking_agc.sv
// Peak-tracking AGC: each envelope sample updates a peak level with instant
// attack and exponential release (peak = max(sample, peak * release)), the
// first sample after reset seeding the peak, and the sample divided by that
// peak comes out as signed Q2.14, saturated, or zero when the peak is not
// positive. The block works on one sample at a time; a two-entry input queue
// and an output register keep both handshakes moving. A sample goes from the
// head of the queue to the output register through a fetch, the 32x32 decay
// multiply, the peak update, the range check and the bit-per-cycle restoring
// divider, then a hand-off. Samples that need no division skip the divider:
// a non-positive peak goes from the peak update to the hand-off (no range
// check), a saturating quotient from the range check. The release factor is
// written through the APB port at byte address 0 while the block is idle; the
// user must keep to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
// peak_tracking_agc
// Top level: release register on the APB port, front queue and back end.
// ----------------------------------------------------------------------------
module peak_tracking_agc (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [pta_pkg::SAMPLE_BITS-1:0] i_envelope_sample,
    input  logic                                   i_block_end,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [pta_pkg::OUT_BITS-1:0]    o_normalized_sample,
    output logic                                   o_last_in_block,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [pta_pkg::PADDR_BITS-1:0]         paddr,
    input  logic [pta_pkg::PDATA_BITS-1:0]         pwdata,
    output logic [pta_pkg::PDATA_BITS-1:0]         prdata,
    output logic                                   pready
);
    import pta_pkg::*;

    logic [REL_BITS-1:0] r_release;
    logic                w_reg_hit;
    t_q_head             w_head;
    logic                w_pop;

    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[PADDR_BITS-1] == REG_RELEASE_IDX);
    assign prdata    = w_reg_hit ? PDATA_BITS'(r_release) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release <= RELEASE_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_release <= REL_BITS'(pwdata);
        end
    end

    pta_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_envelope_sample (i_envelope_sample),
        .i_block_end       (i_block_end),
        .o_head            (w_head),
        .i_pop             (w_pop)
    );

    pta_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_head              (w_head),
        .o_pop               (w_pop),
        .i_release           (r_release),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_normalized_sample (o_normalized_sample),
        .o_last_in_block     (o_last_in_block)
    );

endmodule

FILE: hdl/pta_front.sv
// ----------------------------------------------------------------------------
// pta_front
// Accepts input requests, splits each sample into sign and magnitude and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module pta_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [pta_pkg::SAMPLE_BITS-1:0] i_envelope_sample,
    input  logic                                   i_block_end,
    output pta_pkg::t_q_head                       o_head,
    input  logic                                   i_pop
);
    import pta_pkg::*;

    t_item                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    t_item                w_item;
    logic                 w_push;
    logic                 w_pop;

    always_comb begin
        w_item.sample    = i_envelope_sample;
        w_item.neg       = i_envelope_sample[SAMPLE_BITS-1];
        w_item.mag       = w_item.neg ? SAMPLE_BITS'(-i_envelope_sample)
                                      : SAMPLE_BITS'(i_envelope_sample);
        w_item.block_end = i_block_end;
    end

    assign o_stall      = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign w_push       = i_valid && !o_stall;
    assign w_pop        = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + QCNT_BITS'(1);
                2'b01:   r_count <= r_count - QCNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hdl/pta_back.sv
// ----------------------------------------------------------------------------
// pta_back
// Peak update (decay multiply, max against the sample) and a restoring
// divider that forms sample / peak, then a registered output stage.
// ----------------------------------------------------------------------------
module pta_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pta_pkg::t_q_head                    i_head,
    output logic                                o_pop,
    input  logic [pta_pkg::REL_BITS-1:0]        i_release,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [pta_pkg::OUT_BITS-1:0] o_normalized_sample,
    output logic                                o_last_in_block
);
    import pta_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    t_item                       r_item;
    logic signed [PEAK_BITS-1:0] r_peak;
    logic                        r_seeded;
    logic signed [PROD_BITS-1:0] r_prod;
    logic        [PEAK_BITS-1:0] r_rem;
    logic        [QUO_BITS-1:0]  r_quo;
    logic        [CNT_BITS-1:0]  r_cnt;
    logic                        r_zero;
    logic                        r_sat;
    logic                        r_out_valid;
    logic signed [OUT_BITS-1:0]  r_out_sample;
    logic                        r_out_last;

    logic signed [PEAK_BITS-1:0]   w_s31;
    logic signed [PEAK_BITS-1:0]   w_base;
    logic signed [REL_BITS:0]      w_rel;
    logic signed [PROD_BITS:0]     w_prod;
    logic signed [PEAK_BITS-1:0]   w_decayed;
    logic signed [PEAK_BITS-1:0]   w_new_peak;
    logic                          w_peak_pos;
    logic        [PEAK_BITS-1:0]   w_init_rem;
    logic                          w_sat;
    logic        [PEAK_BITS:0]     w_rem2;
    logic        [PEAK_BITS:0]     w_diff;
    logic                          w_qbit;
    logic                          w_div_last;
    logic signed [OUT_BITS-1:0]    w_result;
    logic                          w_out_load;

    // datapath terms
    assign w_s31      = $signed({r_item.sample, {SAMPLE_SHIFT{1'b0}}});
    assign w_base     = r_seeded ? r_peak : w_s31;
    assign w_rel      = $signed({1'b0, i_release});
    assign w_prod     = w_base * w_rel;
    // arithmetic shift gives the floor of the product
    assign w_decayed  = r_prod[PROD_BITS-1:REL_BITS];
    assign w_new_peak = (w_s31 > w_decayed) ? w_s31 : w_decayed;
    assign w_peak_pos = !w_new_peak[PEAK_BITS-1] && (w_new_peak != '0);
    assign w_init_rem = PEAK_BITS'(r_item.mag) << REM_SHIFT;
    assign w_sat      = (w_init_rem >= r_peak);
    assign w_rem2     = {r_rem, 1'b0};
    assign w_diff     = w_rem2 - {1'b0, r_peak};
    assign w_qbit     = !w_diff[PEAK_BITS];
    assign w_div_last = (r_cnt == CNT_BITS'(QUO_BITS - 1));

    always_comb begin
        priority if (r_zero) begin
            w_result = '0;
        end else if (r_item.neg) begin
            if (r_sat || (r_quo > NEG_LIMIT)) begin
                w_result = OUT_MIN;
            end else begin
                w_result = OUT_BITS'(-r_quo);
            end
        end else begin
            if (r_sat || (r_quo > POS_LIMIT)) begin
                w_result = OUT_MAX;
            end else begin
                w_result = OUT_BITS'(r_quo);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_head.valid) n_state = ST_MUL;
            ST_MUL:  n_state = ST_UPD;
            ST_UPD:  n_state = w_peak_pos ? ST_CHK : ST_DONE;
            ST_CHK:  n_state = w_sat ? ST_DONE : ST_DIV;
            ST_DIV:  if (w_div_last) n_state = ST_DONE;
            ST_DONE: if (w_out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop      = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: o_pop      = i_head.valid;
            ST_DONE: w_out_load = !r_out_valid || !i_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_peak      <= '0;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_UPD) begin
                r_peak   <= w_new_peak;
                r_seeded <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    r_item <= i_head.item;
                end
            end
            ST_MUL: r_prod <= w_prod[PROD_BITS-1:0];
            ST_UPD: begin
                r_zero <= !w_peak_pos;
                r_sat  <= 1'b0;
                r_rem  <= w_init_rem;
                r_quo  <= '0;
                r_cnt  <= '0;
            end
            ST_CHK: r_sat <= w_sat;
            ST_DIV: begin
                // one quotient bit per cycle, restore on a negative trial
                r_rem <= w_qbit ? w_diff[PEAK_BITS-1:0] : w_rem2[PEAK_BITS-1:0];
                r_quo <= {r_quo[QUO_BITS-2:0], w_qbit};
                r_cnt <= r_cnt + CNT_BITS'(1);
            end
            ST_DONE: begin
                if (w_out_load) begin
                    r_out_sample <= w_result;
                    r_out_last   <= r_item.block_end;
                end
            end
            default: ;
        endcase
    end

    assign o_valid             = r_out_valid;
    assign o_normalized_sample = r_out_sample;
    assign o_last_in_block     = r_out_last;

endmodule

FILE: hdl/pta_checker.sv
// ----------------------------------------------------------------------------
// pta_checker
// Port-level checks for the peak-tracking AGC, bound to the top level.
// ----------------------------------------------------------------------------
module pta_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_valid,
    input logic                                   o_stall,
    input logic signed [pta_pkg::SAMPLE_BITS-1:0] i_envelope_sample,
    input logic                                   i_block_end,
    input logic                                   o_valid,
    input logic                                   i_stall,
    input logic signed [pta_pkg::OUT_BITS-1:0]    o_normalized_sample,
    input logic                                   o_last_in_block,
    input logic                                   psel,
    input logic                                   penable,
    input logic                                   pwrite,
    input logic [pta_pkg::PADDR_BITS-1:0]         paddr,
    input logic [pta_pkg::PDATA_BITS-1:0]         pwdata,
    input logic [pta_pkg::PDATA_BITS-1:0]         prdata,
    input logic                                   pready
);
    import pta_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_normalized_sample)
                               && $stable(o_last_in_block))
        else $error("stalled result changed");

    // drop any result and stall on reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result or stall left over from reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

    // read back the release factor after a write
    a_release_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[PADDR_BITS-1] == REG_RELEASE_IDX)
        |=> (paddr[PADDR_BITS-1] != REG_RELEASE_IDX) || (prdata == $past(pwdata)))
        else $error("release factor readback mismatch");

endmodule

bind peak_tracking_agc pta_checker u_pta_checker (.*);
